// ===== sv/simt_call_sequence_decoder_macros.svh =====
// Assertion helpers shared by the decoder modules.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SIMT_CALL_SEQUENCE_DECODER_MACROS_SVH
`define SIMT_CALL_SEQUENCE_DECODER_MACROS_SVH

// Same-cycle implication.
`define SCSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SCSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/scsd_pkg.sv =====
package scsd_pkg;

  // Width of the running byte offset inside one function.
  localparam int OFFSET_WIDTH = 32;
  // Candidate queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Word offset rebuilt from MOVI/MOVK chunks.
  localparam int ENC_W = 48;
  localparam int HIST_DEPTH = 7;

  // Configuration port.
  localparam int CFG_ADDR_W = 4;
  localparam logic REG_FUNCTION_BASE_ADDRESS = 1'b0;

  // Launch instruction: variable fields are code size, two registers and the low bits.
  localparam logic [63:0] LAUNCH_VAR_MASK = (64'hffff << 37) | (64'h1f << 16) |
                                            (64'h1f << 11) | 64'h3ff | (64'h1 << 10);
  localparam logic [63:0] LAUNCH_FIXED_MASK = ~LAUNCH_VAR_MASK;
  localparam logic [63:0] LAUNCH_FIXED_BITS = 64'h15e0001c15200400 & LAUNCH_FIXED_MASK;

  localparam logic [31:0] MOV_PC_MASK = 32'hffc1ffff;
  localparam logic [31:0] MOV_PC_BITS = 32'h02000880;
  localparam logic [31:0] MOVI_MASK   = 32'hffc10000;
  localparam logic [31:0] MOVI_BITS   = 32'h07000000;
  localparam logic [31:0] SHLI_MASK   = 32'hffc1ffff;
  localparam logic [31:0] SHLI_BITS   = 32'h02c00202;
  localparam logic [31:0] ADD_MASK    = 32'hffc0007f;
  localparam logic [31:0] ADD_BITS    = 32'h00000001;
  localparam logic [31:0] NOP_WORD    = 32'h41400000;
  localparam logic [31:0] MOVK_MASK   = 32'hffc10000;
  localparam logic [31:0] MOVK1_BITS  = 32'h07410000;
  localparam logic [31:0] MOVK2_BITS  = 32'h07810000;

  typedef struct packed {
    logic [31:0] code_word;
    logic        function_start;
  } code_t;

  typedef struct packed {
    logic [63:0] site_address;
    logic [63:0] target_address;
    logic [15:0] code_size_field;
    logic [63:0] launch_instruction;
    logic        decode_status;
  } call_t;

  // Launch site found by the front, queued for the back.
  typedef struct packed {
    logic [63:0]             inst;
    logic [OFFSET_WIDTH-1:0] pair_off;
    logic [ENC_W-1:0]        enc;
    logic                    pattern_ok;
    logic                    new_func;
  } cand_t;

  // Back stage after the address adds.
  typedef struct packed {
    logic [63:0]      inst;
    logic [63:0]      site;
    logic [63:0]      pc;
    logic [ENC_W-1:0] enc;
    logic             pattern_ok;
    logic             new_func;
  } stage_t;

  function automatic logic [4:0] reg_of(input logic [31:0] w, input int sh);
    logic [31:0] s;
    s = w >> sh;
    return s[4:0];
  endfunction

  // Upper offset chunk: NOP or MOVK with the given tag on the target register.
  function automatic logic chunk_ok(input logic [31:0] w, input logic [31:0] tag,
                                    input logic [4:0] rg);
    return (w == NOP_WORD) || (((w & MOVK_MASK) == tag) && (reg_of(w, 17) == rg));
  endfunction

  function automatic logic [15:0] chunk_val(input logic [31:0] w);
    return (w == NOP_WORD) ? 16'h0 : w[15:0];
  endfunction

endpackage

// ===== sv/scsd_front.sv =====
`include "simt_call_sequence_decoder_macros.svh"

module scsd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  scsd_pkg::code_t code,
  output logic            push,
  output scsd_pkg::cand_t cand
);

  logic [31:0]                       hist [scsd_pkg::HIST_DEPTH];
  logic [2:0]                        words_seen;
  logic [scsd_pkg::OFFSET_WIDTH-1:0] byte_offset;
  logic                              skip_pair;
  logic                              new_func;

  logic [2:0]                        ws_e;
  logic [scsd_pkg::OFFSET_WIDTH-1:0] off_e;
  logic                              skip_e;
  logic                              newf_e;
  logic [63:0]                       inst;
  logic [4:0]                        rg;
  logic                              hit;
  logic                              seq_ok;

  always_comb begin
    ws_e   = code.function_start ? 3'd0 : words_seen;
    off_e  = code.function_start ? '0 : byte_offset;
    skip_e = code.function_start ? 1'b0 : skip_pair;
    newf_e = code.function_start ? 1'b1 : new_func;

    inst = {code.code_word, hist[0]};
    rg   = inst[20:16];
    hit  = (ws_e != 3'd0) && !skip_e &&
           ((inst & scsd_pkg::LAUNCH_FIXED_MASK) == scsd_pkg::LAUNCH_FIXED_BITS);

    // hist[6] MOV PC, [5] MOVI, [4] MOVK #1, [3] MOVK #2, [2] SHLI, [1] ADD
    seq_ok = (ws_e == 3'd7) &&
             ((hist[6] & scsd_pkg::MOV_PC_MASK) == scsd_pkg::MOV_PC_BITS) &&
             ((hist[5] & scsd_pkg::MOVI_MASK) == scsd_pkg::MOVI_BITS) &&
             ((hist[2] & scsd_pkg::SHLI_MASK) == scsd_pkg::SHLI_BITS) &&
             ((hist[1] & scsd_pkg::ADD_MASK) == scsd_pkg::ADD_BITS) &&
             (scsd_pkg::reg_of(hist[5], 17) == rg) &&
             (scsd_pkg::reg_of(hist[2], 17) == rg) &&
             (scsd_pkg::reg_of(hist[1], 17) == rg) &&
             (scsd_pkg::reg_of(hist[1], 12) == rg) &&
             (scsd_pkg::reg_of(hist[6], 17) == scsd_pkg::reg_of(hist[1], 7)) &&
             scsd_pkg::chunk_ok(hist[4], scsd_pkg::MOVK1_BITS, rg) &&
             scsd_pkg::chunk_ok(hist[3], scsd_pkg::MOVK2_BITS, rg);

    push            = accept && hit;
    cand.inst       = inst;
    cand.pair_off   = off_e - scsd_pkg::OFFSET_WIDTH'(4);
    cand.enc        = {scsd_pkg::chunk_val(hist[3]), scsd_pkg::chunk_val(hist[4]),
                       hist[5][15:0]};
    cand.pattern_ok = seq_ok;
    cand.new_func   = newf_e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_seen  <= 3'd0;
      byte_offset <= '0;
      skip_pair   <= 1'b0;
      new_func    <= 1'b1;
    end else if (accept) begin
      words_seen  <= (ws_e == 3'd7) ? 3'd7 : ws_e + 3'd1;
      byte_offset <= off_e + scsd_pkg::OFFSET_WIDTH'(4);
      // A hit, good or bad, keeps the next pair from being tested.
      skip_pair   <= hit;
      new_func    <= hit ? 1'b0 : newf_e;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = scsd_pkg::HIST_DEPTH - 1; i > 0; i--) begin
        hist[i] <= hist[i-1];
      end
      hist[0] <= code.code_word;
    end
  end

  `SCSD_ASSERT_NEXT(a_front_skip, push, !(accept && !code.function_start && hit), "pair after a hit was tested")

endmodule

// ===== sv/scsd_queue.sv =====
`include "simt_call_sequence_decoder_macros.svh"

module scsd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  scsd_pkg::cand_t push_data,
  output logic            full,
  output logic            head_valid,
  output scsd_pkg::cand_t head,
  input  logic            pop
);

  scsd_pkg::cand_t                  ent [scsd_pkg::QUEUE_DEPTH];
  logic [scsd_pkg::QPTR_W-1:0]      wr_ptr;
  logic [scsd_pkg::QPTR_W-1:0]      rd_ptr;
  logic [scsd_pkg::QCNT_W-1:0]      count;

  function automatic logic [scsd_pkg::QPTR_W-1:0] bump(input logic [scsd_pkg::QPTR_W-1:0] p);
    return (p == scsd_pkg::QPTR_W'(scsd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count == scsd_pkg::QCNT_W'(scsd_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_data;
    end
  end

  `SCSD_ASSERT_IMP(a_q_no_overflow, push, !full || pop, "push into full queue")
  `SCSD_ASSERT_IMP(a_q_no_underflow, pop, head_valid, "pop from empty queue")
  `SCSD_ASSERT_IMP(a_q_count, 1'b1, count <= scsd_pkg::QCNT_W'(scsd_pkg::QUEUE_DEPTH), "queue count out of range")

endmodule

// ===== sv/scsd_back.sv =====
`include "simt_call_sequence_decoder_macros.svh"

module scsd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic [63:0]     base,
  input  logic            head_valid,
  input  scsd_pkg::cand_t head,
  output logic            pop,
  output logic            call_valid,
  input  logic            call_stall,
  output scsd_pkg::call_t call
);

  localparam int OW = scsd_pkg::OFFSET_WIDTH;

  scsd_pkg::stage_t a;
  scsd_pkg::stage_t a_next;
  logic             a_valid;
  logic             dropping;

  logic [OW:0]      pc_delta;
  logic [65:0]      sum;
  logic             a_ok;
  logic             a_discard;
  logic             a_move;
  logic             out_free;

  always_comb begin
    // MOV PC sits six words before the pair.
    pc_delta          = {1'b0, head.pair_off} - (OW+1)'(24);
    a_next.inst       = head.inst;
    a_next.site       = base + 64'(head.pair_off);
    a_next.pc         = base + {{(63-OW){pc_delta[OW]}}, pc_delta};
    a_next.enc        = head.enc;
    a_next.pattern_ok = head.pattern_ok;
    a_next.new_func   = head.new_func;

    // Target must land inside the 64-bit space.
    sum  = {2'b00, a.pc} + {{(64-scsd_pkg::ENC_W){a.enc[scsd_pkg::ENC_W-1]}}, a.enc, 2'b00};
    a_ok = a.pattern_ok && (sum[65:64] == 2'b00);

    a_discard = dropping && !a.new_func;
    out_free  = !call_valid || !call_stall;
    a_move    = a_valid && (a_discard || out_free);
    pop       = head_valid && (!a_valid || a_move);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      dropping   <= 1'b0;
      call_valid <= 1'b0;
    end else begin
      if (pop) begin
        a_valid <= 1'b1;
      end else if (a_move) begin
        a_valid <= 1'b0;
      end
      if (a_move && !a_discard) begin
        dropping <= !a_ok;
      end
      if (out_free) begin
        call_valid <= a_move && !a_discard;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a <= a_next;
    end
    if (out_free && a_move && !a_discard) begin
      call.site_address       <= a.site;
      call.target_address     <= a_ok ? sum[63:0] : 64'h0;
      call.code_size_field    <= a.inst[52:37];
      call.launch_instruction <= a.inst;
      call.decode_status      <= !a_ok;
    end
  end

  `SCSD_ASSERT_NEXT(a_back_latch_err, a_move && !a_discard && !a_ok, dropping, "error did not latch")

endmodule

// ===== sv/simt_call_sequence_decoder.sv =====
// Channel   Role    Handshake              Beat
// code      input   code_valid/code_stall  code_word, function_start
// call      output  call_valid/call_stall  site, target, code size, instruction, status
// config    APB     psel/penable/pready    function_base_address at byte address 0
//
// One code word is taken every cycle unless code_stall is high; the front tests each
// word pair in the cycle it arrives. A found launch site passes through the site queue,
// the back's address stage and the output register before it shows on call.
// code_stall rises only when the four-entry site queue is full, which needs call_stall
// held while sites keep coming.
// rst is synchronous and clears control state only; the word history is not cleared.
module simt_call_sequence_decoder (
  input  logic                              clk,
  input  logic                              rst,
  // code words
  input  logic                              code_valid,
  output logic                              code_stall,
  input  scsd_pkg::code_t                   code,
  // decoded call sites
  output logic                              call_valid,
  input  logic                              call_stall,
  output scsd_pkg::call_t                   call,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [scsd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [63:0]                       pwdata,
  output logic [63:0]                       prdata,
  output logic                              pready
);

  logic [63:0]     function_base_address;
  logic            code_accept;
  logic            push;
  scsd_pkg::cand_t cand;
  logic            q_full;
  logic            head_valid;
  scsd_pkg::cand_t head;
  logic            pop;
  logic            cfg_write;
  logic            reg_sel;

  // Register index sits above the 8-byte lane.
  assign reg_sel   = (paddr[3] == scsd_pkg::REG_FUNCTION_BASE_ADDRESS);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = reg_sel ? function_base_address : 64'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      function_base_address <= 64'h0;
    end else if (cfg_write && reg_sel) begin
      function_base_address <= pwdata;
    end
  end

  // Hold the code stream only while the site queue has no room.
  assign code_stall  = q_full;
  assign code_accept = code_valid && !code_stall;

  // Front: word history, offsets, pair test and sequence check.
  scsd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (code_accept),
    .code   (code),
    .push   (push),
    .cand   (cand)
  );

  // Queue: decouple the front from stalls at the result port.
  scsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (cand),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Back: addresses, target range check, drop after an error, result register.
  scsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .base       (function_base_address),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .call_valid (call_valid),
    .call_stall (call_stall),
    .call       (call)
  );

endmodule
